// ===== hw/rtl/bsv_pkg.sv =====
`default_nettype none
package bsv_pkg;

  localparam int DEPTH = 16;
  localparam int WIDTH = 32;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CFG_W = 5;
  localparam int OP_W  = 3;

  localparam logic [CFG_W-1:0] LIMIT_RESET = CFG_W'(16);
  localparam logic [CNT_W-1:0] DEPTH_CNT   = CNT_W'(DEPTH);

  localparam logic [OP_W-1:0] OP_PUSH  = 3'd0;
  localparam logic [OP_W-1:0] OP_INSERT = 3'd1;
  localparam logic [OP_W-1:0] OP_ERASE = 3'd2;
  localparam logic [OP_W-1:0] OP_POP   = 3'd3;
  localparam logic [OP_W-1:0] OP_READ  = 3'd4;
  localparam logic [OP_W-1:0] OP_CLEAR = 3'd5;

  // Broadcast to every cell of the row in the cycle a request is taken
  typedef struct packed {
    logic             ins_en;
    logic             push_en;
    logic             era_en;
    logic [IDX_W-1:0] idx;
    logic [CNT_W-1:0] count;
    logic [WIDTH-1:0] word;
  } cell_ctrl_t;

endpackage
`default_nettype wire

// ===== hw/rtl/bounded_shift_vector.sv =====
// The result of an accepted request is registered and shows on the out_ side in the cycle after it is taken.
// Throughput: one request per cycle; each cell of the row loads, shifts or
// holds its word in the same cycle, so insert and erase move the whole row at once.
// A result waiting in the output register blocks a new request only while
// out_tready is low.
// Reset (rst_n low, synchronous): count 0, capacity limit 16, no result pending.
`default_nettype none
module bounded_shift_vector
  import bsv_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [4:0]  cfg_data,   // capacity_limit
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // index[3:0], value[35:4], zero pad
  input  wire logic [2:0]  in_tuser,   // opcode
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata   // ok, read_value, count, full_res, empty_res
);

  logic [CFG_W-1:0] limit_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             out_valid_r;
  logic [39:0]      out_data_r;
  logic [39:0]      out_data_nxt;

  logic [OP_W-1:0]  op;
  logic [IDX_W-1:0] idx;
  logic [WIDTH-1:0] word;
  logic [CNT_W-1:0] idx_ext;
  logic [CNT_W-1:0] limit_eff;
  logic             take;
  logic             has_room;
  logic             in_range;
  logic             ok;
  logic [WIDTH-1:0] rd;
  cell_ctrl_t       ctrl;
  logic [WIDTH-1:0] cell_q [DEPTH];

  assign op      = in_tuser;
  assign idx     = in_tdata[IDX_W-1:0];
  assign word    = in_tdata[IDX_W +: WIDTH];
  assign idx_ext = CNT_W'(idx);

  assign limit_eff = (CNT_W'(limit_r) > DEPTH_CNT) ? DEPTH_CNT : CNT_W'(limit_r);
  assign has_room  = count_r < limit_eff;
  assign in_range  = idx_ext < count_r;

  assign in_tready = !out_valid_r || out_tready;
  assign take      = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  always_comb begin
    ok        = 1'b0;
    count_nxt = count_r;
    rd        = '0;
    unique case (op)
      OP_PUSH: begin
        if (has_room) begin
          ok        = 1'b1;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      OP_INSERT: begin
        if (has_room && idx_ext <= count_r) begin
          ok        = 1'b1;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      OP_ERASE: begin
        if (in_range) begin
          ok        = 1'b1;
          count_nxt = count_r - CNT_W'(1);
        end
      end
      OP_POP: begin
        if (count_r != '0) begin
          ok        = 1'b1;
          count_nxt = count_r - CNT_W'(1);
        end
      end
      OP_READ: begin
        if (in_range) begin
          ok = 1'b1;
          rd = cell_q[idx];
        end
      end
      OP_CLEAR: begin
        ok        = 1'b1;
        count_nxt = '0;
      end
      default: begin
        ok = 1'b0;
      end
    endcase
  end

  always_comb begin
    ctrl.ins_en  = take && ok && op == OP_INSERT;
    ctrl.push_en = take && ok && op == OP_PUSH;
    ctrl.era_en  = take && ok && op == OP_ERASE;
    ctrl.idx     = idx;
    ctrl.count   = count_r;
    ctrl.word    = word;
  end

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      logic [WIDTH-1:0] lower_q;
      logic [WIDTH-1:0] upper_q;
      if (g == 0) begin : g_first
        assign lower_q = word;
      end else begin : g_mid_lo
        assign lower_q = cell_q[g-1];
      end
      if (g == DEPTH - 1) begin : g_last
        assign upper_q = '0;
      end else begin : g_mid_hi
        assign upper_q = cell_q[g+1];
      end
      bsv_cell u_cell (
        .clk     (clk),
        .pos     (IDX_W'(g)),
        .ctrl    (ctrl),
        .lower_q (lower_q),
        .upper_q (upper_q),
        .data_q  (cell_q[g])
      );
    end
  endgenerate

  assign out_data_nxt = {(count_nxt == '0), (count_nxt >= limit_eff), count_nxt, rd, ok};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r     <= LIMIT_RESET;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        limit_r <= cfg_data;
      end
      if (take) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // hold the result until it is taken
  always_ff @(posedge clk) begin
    if (take) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
`default_nettype wire

// ===== hw/rtl/bsv_cell.sv =====
`default_nettype none
module bsv_cell
  import bsv_pkg::*;
(
  input  wire logic             clk,
  input  wire logic [IDX_W-1:0] pos,
  input  wire cell_ctrl_t       ctrl,
  input  wire logic [WIDTH-1:0] lower_q,
  input  wire logic [WIDTH-1:0] upper_q,
  output logic      [WIDTH-1:0] data_q
);

  logic [WIDTH-1:0] data_r;
  logic [WIDTH-1:0] data_nxt;
  logic [CNT_W-1:0] pos_ext;
  logic [CNT_W-1:0] idx_ext;
  logic             take_word;
  logic             take_lower;
  logic             take_upper;

  assign pos_ext = CNT_W'(pos);
  assign idx_ext = CNT_W'(ctrl.idx);

  assign take_word  = (ctrl.ins_en && pos_ext == idx_ext) ||
                      (ctrl.push_en && pos_ext == ctrl.count);
  // insert opens a gap at idx: entries from idx up to the old end move up
  assign take_lower = ctrl.ins_en && pos_ext > idx_ext && pos_ext <= ctrl.count;
  // erase closes the gap: entries above idx move down
  assign take_upper = ctrl.era_en && pos_ext >= idx_ext &&
                      (pos_ext + CNT_W'(1)) < ctrl.count;

  always_comb begin
    priority if (take_word) begin
      data_nxt = ctrl.word;
    end else if (take_lower) begin
      data_nxt = lower_q;
    end else if (take_upper) begin
      data_nxt = upper_q;
    end else begin
      data_nxt = data_r;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_q = data_r;

endmodule
`default_nettype wire

// ===== hw/rtl/bsv_checker.sv =====
`default_nettype none
module bsv_checker
  import bsv_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        cfg_valid,
  input wire logic        cfg_ready,
  input wire logic [4:0]  cfg_data,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic [39:0] in_tdata,
  input wire logic [2:0]  in_tuser,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [39:0] out_tdata
);

  logic cfg_seen;
  assign cfg_seen = cfg_valid && cfg_ready && (cfg_data != 5'd0 || in_tdata != '0);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result pending after reset");

  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[39] == (out_tdata[37:33] == 5'd0))
    else $error("empty flag disagrees with count");

  a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> out_tdata[32:1] == 32'd0)
    else $error("refused request returned data");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == OP_CLEAR && !cfg_seen |=>
      out_tvalid && out_tdata[0] && out_tdata[37:33] == 5'd0)
    else $error("clear did not empty the vector");

endmodule

bind bounded_shift_vector bsv_checker u_bsv_checker (.*);
`default_nettype wire

// ===== dv/tb_bounded_shift_vector.sv =====
`timescale 1ns / 100ps
module tb_bounded_shift_vector;
  import bsv_pkg::*;

  // Opcodes the block must refuse
  localparam logic [OP_W-1:0] OP_RSVD6 = 3'd6;
  localparam logic [OP_W-1:0] OP_RSVD7 = 3'd7;

  // Mirrors out_tdata from the lowest bit up: ok, read_value, count, full_res, empty_res
  typedef struct packed {
    logic             empty_res;
    logic             full_res;
    logic [CNT_W-1:0] count;
    logic [WIDTH-1:0] read_value;
    logic             ok;
  } vec_result_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CFG_W-1:0]  cfg_data = '0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [39:0]       in_tdata = '0;   // index[3:0], value[35:4], zero pad
  logic [OP_W-1:0]   in_tuser = '0;   // opcode
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [39:0]       out_tdata;       // ok, read_value, count, full_res, empty_res

  // Shadow of the vector contents and the written limit
  logic [WIDTH-1:0]  vec_words [DEPTH];
  int                vec_count = 0;
  logic [CFG_W-1:0]  vec_limit = LIMIT_RESET;

  vec_result_t       pending_results [$];
  int                mismatches = 0;
  bit                stall_on = 1'b1;
  int                hold_cycles = 0;

  bounded_shift_vector DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #800000;
    $display("CHECK FAILED");
    $finish;
  end

  // Apply one request to the shadow vector and return the result it must produce
  function automatic vec_result_t vector_apply(logic [OP_W-1:0] op, logic [IDX_W-1:0] idx,
                                               logic [WIDTH-1:0] val);
    vec_result_t r;
    int          lim;
    int          n;
    lim = (vec_limit > DEPTH) ? DEPTH : vec_limit;
    n = vec_count;
    r = '0;
    case (op)
      OP_PUSH: begin
        if (n < lim) begin
          vec_words[n] = val;
          n++;
          r.ok = 1'b1;
        end
      end
      OP_INSERT: begin
        if (n < lim && idx <= n) begin
          for (int i = n; i > idx; i--) vec_words[i] = vec_words[i-1];
          vec_words[idx] = val;
          n++;
          r.ok = 1'b1;
        end
      end
      OP_ERASE: begin
        if (idx < n) begin
          for (int i = idx; i + 1 < n; i++) vec_words[i] = vec_words[i+1];
          n--;
          r.ok = 1'b1;
        end
      end
      OP_POP: begin
        if (n > 0) begin
          n--;
          r.ok = 1'b1;
        end
      end
      OP_READ: begin
        if (idx < n) begin
          r.read_value = vec_words[idx];
          r.ok = 1'b1;
        end
      end
      OP_CLEAR: begin
        n = 0;
        r.ok = 1'b1;
      end
      default: ;
    endcase
    vec_count = n;
    r.count = CNT_W'(n);
    r.full_res = (n >= lim);
    r.empty_res = (n == 0);
    return r;
  endfunction

  // Offer one request; valid stays high on return so back-to-back requests stay glued unless stall_on adds an idle gap
  task automatic send_request(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                              input logic [WIDTH-1:0] val);
    while (stall_on && $urandom_range(99) < 18) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'b0, val, idx};
    in_tuser  <= op;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_results.push_back(vector_apply(op, idx, val));
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_limit(input logic [CFG_W-1:0] lim);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= lim;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    vec_limit = lim;
  endtask

  // Mostly well-formed requests: indexes aimed inside the vector, some aimed anywhere
  task automatic random_request();
    int               pick;
    logic [OP_W-1:0]  op;
    logic [IDX_W-1:0] idx;
    pick = $urandom_range(99);
    if (pick < 30)      op = OP_PUSH;
    else if (pick < 50) op = OP_INSERT;
    else if (pick < 65) op = OP_ERASE;
    else if (pick < 75) op = OP_POP;
    else if (pick < 95) op = OP_READ;
    else if (pick < 97) op = OP_CLEAR;
    else                op = $urandom_range(1) ? OP_RSVD6 : OP_RSVD7;
    idx = IDX_W'($urandom_range(DEPTH - 1));
    if ($urandom_range(99) < 80) begin
      if (op == OP_INSERT) idx = IDX_W'($urandom_range(vec_count > DEPTH - 1 ? DEPTH - 1 : vec_count));
      else if (vec_count > 0) idx = IDX_W'($urandom_range(vec_count - 1));
    end
    send_request(op, idx, $urandom);
  endtask

  task automatic test_empty_and_basic();
    send_request(OP_POP,    4'd0,  32'h0);
    send_request(OP_ERASE,  4'd0,  32'h0);
    send_request(OP_READ,   4'd0,  32'h0);
    send_request(OP_PUSH,   4'd0,  32'hFFFF_FFFF);
    send_request(OP_PUSH,   4'd0,  32'h0000_0000);
    send_request(OP_INSERT, 4'd0,  32'hA5A5_A5A5);
    send_request(OP_INSERT, 4'd4,  32'h1234_5678);  // past the count
    send_request(OP_INSERT, 4'd3,  32'h5A5A_5A5A);  // at the count: append
    send_request(OP_READ,   4'd0,  32'h0);
    send_request(OP_READ,   4'd3,  32'h0);
    send_request(OP_READ,   4'd15, 32'h0);
    send_request(OP_ERASE,  4'd1,  32'h0);
    send_request(OP_RSVD6,  4'd15, 32'hFFFF_FFFF);
    send_request(OP_RSVD7,  4'd15, 32'hFFFF_FFFF);
    send_request(OP_CLEAR,  4'd0,  32'h0);
    send_request(OP_READ,   4'd0,  32'h0);
  endtask

  task automatic test_limit_corners();
    write_limit(5'd0);   // always full
    send_request(OP_PUSH,   4'd0, 32'hDEAD_BEEF);
    send_request(OP_INSERT, 4'd0, 32'hDEAD_BEEF);
    write_limit(5'd1);
    send_request(OP_PUSH,   4'd0, 32'h0000_0001);
    send_request(OP_PUSH,   4'd0, 32'h0000_0002);
    write_limit(5'd16);
    send_request(OP_PUSH,   4'd0, 32'h8000_0000);
    send_request(OP_PUSH,   4'd0, 32'h7FFF_FFFF);
    write_limit(5'd2);   // below the count: stored words stay
    send_request(OP_PUSH,   4'd0, 32'h1111_1111);
    send_request(OP_INSERT, 4'd1, 32'h2222_2222);
    send_request(OP_READ,   4'd2, 32'h0);
    send_request(OP_POP,    4'd0, 32'h0);
  endtask

  task automatic test_random_mix(input int n, input logic [CFG_W-1:0] lim, input bit stalls);
    write_limit(lim);
    stall_on = stalls;
    repeat (n) random_request();
  endtask

  task automatic test_output_backpressure();
    write_limit(5'd12);
    stall_on = 1'b1;
    hold_cycles = 80;
    repeat (30) random_request();
  endtask

  // Result consumer: random stalls while stall_on is set, or a long hold when one is requested
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      out_tready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_tready <= !stall_on || ($urandom_range(99) >= 18);
    end
  end

  always @(posedge clk) begin
    vec_result_t got;
    vec_result_t want;
    bit          bad;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (pending_results.size() == 0) begin
        $error("result with no request outstanding: %h", out_tdata);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        bad = 1'b0;
        if (got.ok !== want.ok) begin
          $error("ok: expected %0d, got %0d", want.ok, got.ok);
          bad = 1'b1;
        end
        if (got.read_value !== want.read_value) begin
          $error("read_value: expected %h, got %h", want.read_value, got.read_value);
          bad = 1'b1;
        end
        if (got.count !== want.count) begin
          $error("count: expected %0d, got %0d", want.count, got.count);
          bad = 1'b1;
        end
        if (got.full_res !== want.full_res) begin
          $error("full_res: expected %0d, got %0d", want.full_res, got.full_res);
          bad = 1'b1;
        end
        if (got.empty_res !== want.empty_res) begin
          $error("empty_res: expected %0d, got %0d", want.empty_res, got.empty_res);
          bad = 1'b1;
        end
        if (bad) mismatches++;
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_and_basic();
    test_limit_corners();
    test_random_mix(500, 5'd16, 1'b1);
    test_random_mix(350, 5'd31, 1'b0);  // saturates to the depth; no idling
    test_random_mix(250, 5'd5,  1'b1);
    test_random_mix(150, 5'd1,  1'b1);
    test_random_mix(60,  5'd0,  1'b1);
    test_output_backpressure();
    test_random_mix(200, 5'd12, 1'b1);
    test_random_mix(300, 5'd16, 1'b1);
    drain_results();
    repeat (4) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/bsv_pkg.sv
hw/rtl/bsv_cell.sv
hw/rtl/bounded_shift_vector.sv
hw/rtl/bsv_checker.sv
dv/tb_bounded_shift_vector.sv
